FILE: rtl/strg_pkg.sv
// Package for the sine tone ramp generator: field widths, register indexes,
// the sequencer's control-word types and its microprogram.
// No dependencies; the top level imports it.
package strg_pkg;

    // Field widths of the stream payloads and the configuration port.
    localparam int FRAMES_W     = 9;
    localparam int AMP_W        = 15;
    localparam int TUNE_W       = 16;
    localparam int SAMPLE_W     = 16;
    localparam int IN_TUSER_W   = 2;
    localparam int IN_TDATA_W   = ((FRAMES_W + 2 * AMP_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W  = SAMPLE_W;
    localparam int CFG_INDEX_W  = 1;
    localparam int CFG_DATA_W   = 16;

    // Fixed-point formats of the datapath.
    localparam int AMP_FRAC   = 10;
    localparam int ACC_W      = AMP_W + AMP_FRAC;
    localparam int DIV_W      = ACC_W;
    localparam int EDGE_W     = 7;
    localparam int ENV_FRAC   = 16;
    localparam int ENV_W      = ENV_FRAC + 1;
    localparam int SINE_W     = 15;
    localparam int PROD_W     = SINE_W + ACC_W + ENV_W;
    localparam int PROD_SHIFT = 41;
    localparam int CNT_W      = 5;
    localparam int DIV_STEPS  = DIV_W;

    // Constants of the envelope and the output clamp.
    localparam logic [FRAMES_W-1:0] FADE_MIN_LEN   = 9'd32;
    localparam logic [FRAMES_W-1:0] EDGE_MAX       = 9'd80;
    localparam int                  EDGE_DIV_SHIFT = 3;
    localparam logic [ENV_W-1:0]    ENV_UNITY      = 17'h10000;
    localparam logic [SAMPLE_W-1:0] SAMPLE_POS_MAX = 16'h7FFF;
    localparam logic [SAMPLE_W-1:0] SAMPLE_NEG_MAG = 16'h8000;
    localparam logic [AMP_W-1:0]    MAX_AMP_RESET  = 15'd14000;
    localparam logic [63:0]         HALF_PI_Q30    = 64'd1686629713;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_TUNING_WORD   = 1'b0,
        REG_MAX_AMPLITUDE = 1'b1
    } cfg_reg_t;

    // Datapath operations selected by a control word.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_LOAD,
        OP_DIV,
        OP_SET_INC,
        OP_CHECK,
        OP_SET_ENV,
        OP_MUL_LOAD1,
        OP_MUL_LOAD2,
        OP_MUL,
        OP_EMIT
    } op_t;

    // Jump conditions: a true condition jumps to the target step.
    typedef enum logic [2:0] {
        C_NEXT,
        C_NO_BEAT,
        C_NOT_FIRST,
        C_SHORT,
        C_MORE,
        C_NO_FADE,
        C_OUT_BUSY
    } cond_t;

    // Program steps.
    typedef enum logic [3:0] {
        S_WAIT,
        S_TEST,
        S_LOAD,
        S_DIVI,
        S_SETI,
        S_CHECK,
        S_DIVE,
        S_SETE,
        S_MUL1L,
        S_MUL1,
        S_MUL2L,
        S_MUL2,
        S_OUT
    } step_t;

    localparam int    STEP_W     = 4;
    localparam int    STEP_COUNT = 13;
    localparam step_t STEP_LAST  = S_OUT;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
    } ucode_t;

    // Datapath enables decoded from the current control word.
    typedef struct packed {
        logic capture;
        logic load;
        logic div_step;
        logic set_inc;
        logic check;
        logic set_env;
        logic mul_load1;
        logic mul_load2;
        logic mul_step;
        logic emit;
    } ctrl_t;

    // Microprogram, one control word per step in step order.
    localparam ucode_t UCODE [STEP_COUNT] = '{
        '{OP_CAPTURE,   C_NO_BEAT,   S_WAIT},   // wait for a request beat
        '{OP_NONE,      C_NOT_FIRST, S_CHECK},  // skip the chunk load
        '{OP_LOAD,      C_SHORT,     S_CHECK},  // load chunk, no ramp if one frame
        '{OP_DIV,       C_MORE,      S_DIVI},   // ramp increment division
        '{OP_SET_INC,   C_NEXT,      S_WAIT},
        '{OP_CHECK,     C_NO_FADE,   S_MUL1L},  // sine read, envelope choice
        '{OP_DIV,       C_MORE,      S_DIVE},   // fade envelope division
        '{OP_SET_ENV,   C_NEXT,      S_WAIT},
        '{OP_MUL_LOAD1, C_NEXT,      S_WAIT},
        '{OP_MUL,       C_MORE,      S_MUL1},   // sine times amplitude
        '{OP_MUL_LOAD2, C_NEXT,      S_WAIT},
        '{OP_MUL,       C_MORE,      S_MUL2},   // times envelope
        '{OP_EMIT,      C_OUT_BUSY,  S_OUT}     // hold until the output is free
    };

endpackage

FILE: rtl/sine_tone_ramp_generator.sv
// Top level of the sine tone ramp generator: microcoded sequencer, sine
// table, serial divider and serial multiplier.
// Depends on strg_pkg.

// One request beat in gives one sample beat out. An item runs the fade
// envelope division only when the frame lies in a fade-in or fade-out, and
// the ramp increment division only when it loads a chunk longer than one
// frame; the output side can stall a finished sample while it waits. The
// restoring divider takes 25 steps per division, and the shift-add
// multiplier takes 15 steps for sine times amplitude and 17 for the
// envelope. The next request is taken as soon as a sample moves to the
// output register. The sine table is a constant quarter wave and needs no
// fill after reset. Configuration writes are accepted in every cycle.
module sine_tone_ramp_generator
    import strg_pkg::*;
#(
    parameter int CHUNK_MAX      = 256,
    parameter int PHASE_BITS     = 16,
    parameter int SINE_ADDR_BITS = 10
)(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // chunk_frames[8:0], amp_start[23:9], amp_end[38:24], zero pad [39]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // start_tone[0], chunk_first[1]
    input  logic [IN_TUSER_W-1:0]  s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // sample[15:0]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                   m_axis_tlast,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int QBITS      = SINE_ADDR_BITS - 2;
    localparam int QUARTER    = 1 << QBITS;
    localparam int IDX_W      = QBITS + 1;
    localparam int LEN_FULL_W = $clog2(CHUNK_MAX + 1);
    localparam int LEN_W      = (LEN_FULL_W < FRAMES_W) ? LEN_FULL_W : FRAMES_W;

    // Quarter-wave sine entry in unsigned Q0.15, evaluated at elaboration only.
    function automatic logic [SINE_W-1:0] quarter_sine(input int unsigned num);
        logic [63:0] y;
        logic [63:0] y2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] scaled;
        y      = (64'(num) * HALF_PI_Q30) >> QBITS;
        y2     = (y * y) >> 30;
        term   = y;
        sum    = y;
        term   = ((term * y2) >> 30) / 64'd6;
        sum    = sum - term;
        term   = ((term * y2) >> 30) / 64'd20;
        sum    = sum + term;
        term   = ((term * y2) >> 30) / 64'd42;
        sum    = sum - term;
        term   = ((term * y2) >> 30) / 64'd72;
        sum    = sum + term;
        term   = ((term * y2) >> 30) / 64'd110;
        sum    = sum - term;
        term   = ((term * y2) >> 30) / 64'd156;
        sum    = sum + term;
        term   = ((term * y2) >> 30) / 64'd210;
        sum    = sum - term;
        scaled = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
        return scaled[SINE_W-1:0];
    endfunction

    // Configuration and sequencer registers.
    logic [TUNE_W-1:0]       tuning_word_reg;
    logic [AMP_W-1:0]        max_amp_reg;
    step_t                   step_reg;
    step_t                   step_next;
    logic [CNT_W-1:0]        cnt_reg;
    ucode_t                  uc;
    ctrl_t                   ctrl;
    logic                    jump;

    // Tone and chunk state.
    logic [PHASE_BITS-1:0]   phase_reg;
    logic [LEN_W-1:0]        frame_index_reg;
    logic [LEN_W-1:0]        chunk_length_reg;
    logic [EDGE_W-1:0]       edge_length_reg;
    logic [ACC_W-1:0]        amp_accum_reg;
    logic [ACC_W-1:0]        amp_inc_reg;
    logic                    inc_neg_reg;

    // Captured request fields.
    logic                    first_reg;
    logic [FRAMES_W-1:0]     frames_reg;
    logic [AMP_W-1:0]        amp_start_reg;
    logic [AMP_W-1:0]        amp_end_reg;

    // Per-frame working registers.
    logic                    active_reg;
    logic                    sine_neg_reg;
    logic [SINE_W-1:0]       sine_mag_reg;
    logic [ENV_W-1:0]        env_reg;
    logic [DIV_W-1:0]        div_num_reg;
    logic [FRAMES_W-1:0]     div_rem_reg;
    logic [FRAMES_W-1:0]     div_den_reg;
    logic [PROD_W-1:0]       mul_acc_reg;
    logic [PROD_W-1:0]       mul_cand_reg;
    logic [ENV_W-1:0]        mul_plier_reg;

    // Output register.
    logic                    out_valid_reg;
    logic signed [SAMPLE_W-1:0] out_sample_reg;
    logic                    out_done_reg;

    // Combinational helpers.
    logic                    out_free;
    logic [FRAMES_W-1:0]     len_clamp;
    logic                    len_short;
    logic [FRAMES_W-1:0]     len_eighth;
    logic [EDGE_W-1:0]       edge_calc;
    logic [AMP_W-1:0]        amp0_clamp;
    logic [AMP_W-1:0]        amp1_clamp;
    logic                    amp_falls;
    logic [AMP_W-1:0]        amp_diff;
    logic [FRAMES_W-1:0]     i_ext;
    logic [FRAMES_W-1:0]     len_ext;
    logic [FRAMES_W-1:0]     edge_ext;
    logic                    frame_live;
    logic                    fade_in;
    logic                    fade_out;
    logic                    no_fade;
    logic [FRAMES_W-1:0]     env_num_wide;
    logic [EDGE_W-1:0]       env_num;
    logic [SINE_ADDR_BITS-1:0] sine_addr;
    logic [1:0]              sine_quad;
    logic [QBITS-1:0]        sine_off;
    logic [IDX_W-1:0]        rom_idx;
    logic [SINE_W-1:0]       sine_tab [QUARTER+1];
    logic [FRAMES_W:0]       div_trial;
    logic                    div_qbit;
    logic [FRAMES_W-1:0]     div_rem_next;
    logic [LEN_W-1:0]        frame_next;
    logic [SAMPLE_W-1:0]     prod_mag;
    logic [SAMPLE_W-1:0]     sat_mag;
    logic [SAMPLE_W-1:0]     sample_calc;
    logic                    done_calc;

    // Constant quarter-wave sine table.
    for (genvar k = 0; k <= QUARTER; k++)
    begin : g_sine
        assign sine_tab[k] = quarter_sine(k);
    end

    // Port handshakes.
    assign s_axis_tready = (step_reg == S_WAIT);
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_sample_reg;
    assign m_axis_tlast  = out_done_reg;
    assign out_free      = !out_valid_reg || m_axis_tready;

    // Current control word.
    assign uc = UCODE[step_reg];

    // Chunk load arithmetic: clamps, fade length and ramp difference.
    always_comb
    begin
        if (frames_reg == '0)
        begin
            len_clamp = FRAMES_W'(1);
        end
        else if (32'(frames_reg) > CHUNK_MAX)
        begin
            len_clamp = FRAMES_W'(CHUNK_MAX);
        end
        else
        begin
            len_clamp = frames_reg;
        end
        len_short  = len_clamp < FRAMES_W'(2);
        len_eighth = len_clamp >> EDGE_DIV_SHIFT;
        if (len_clamp > FADE_MIN_LEN)
        begin
            edge_calc = (len_eighth < EDGE_MAX) ? EDGE_W'(len_eighth) : EDGE_W'(EDGE_MAX);
        end
        else
        begin
            edge_calc = '0;
        end
        amp0_clamp = (amp_start_reg > max_amp_reg) ? max_amp_reg : amp_start_reg;
        amp1_clamp = (amp_end_reg > max_amp_reg) ? max_amp_reg : amp_end_reg;
        amp_falls  = amp1_clamp < amp0_clamp;
        amp_diff   = amp_falls ? (amp0_clamp - amp1_clamp) : (amp1_clamp - amp0_clamp);
    end

    // Frame check: live frame, fade region and envelope numerator.
    always_comb
    begin
        i_ext        = FRAMES_W'(frame_index_reg);
        len_ext      = FRAMES_W'(chunk_length_reg);
        edge_ext     = FRAMES_W'(edge_length_reg);
        frame_live   = frame_index_reg < chunk_length_reg;
        fade_in      = i_ext < edge_ext;
        fade_out     = i_ext >= (len_ext - edge_ext);
        no_fade      = !frame_live || (edge_length_reg == '0) || !(fade_in || fade_out);
        env_num_wide = fade_in ? (i_ext + FRAMES_W'(1)) : (len_ext - i_ext);
        env_num      = env_num_wide[EDGE_W-1:0];
    end

    // Sine table address from the top phase bits, folded to a quarter wave.
    if (PHASE_BITS >= SINE_ADDR_BITS)
    begin : g_addr_cut
        assign sine_addr = phase_reg[PHASE_BITS-1 -: SINE_ADDR_BITS];
    end
    else
    begin : g_addr_pad
        assign sine_addr = {phase_reg, {(SINE_ADDR_BITS - PHASE_BITS){1'b0}}};
    end

    assign sine_quad = sine_addr[SINE_ADDR_BITS-1 -: 2];
    assign sine_off  = sine_addr[QBITS-1:0];
    assign rom_idx   = sine_quad[0] ? (IDX_W'(QUARTER) - {1'b0, sine_off}) : {1'b0, sine_off};

    // One restoring division step.
    always_comb
    begin
        div_trial = {div_rem_reg, div_num_reg[DIV_W-1]};
        div_qbit  = div_trial >= {1'b0, div_den_reg};
        if (div_qbit)
        begin
            div_rem_next = FRAMES_W'(div_trial - {1'b0, div_den_reg});
        end
        else
        begin
            div_rem_next = div_trial[FRAMES_W-1:0];
        end
    end

    // Sample scaling, saturation and end-of-chunk flag.
    always_comb
    begin
        frame_next = frame_index_reg + LEN_W'(1);
        prod_mag   = mul_acc_reg[PROD_W-1 -: SAMPLE_W];
        if (sine_neg_reg)
        begin
            sat_mag     = (prod_mag > SAMPLE_NEG_MAG) ? SAMPLE_NEG_MAG : prod_mag;
            sample_calc = SAMPLE_W'(0) - sat_mag;
        end
        else
        begin
            sat_mag     = (prod_mag > SAMPLE_POS_MAX) ? SAMPLE_POS_MAX : prod_mag;
            sample_calc = sat_mag;
        end
        if (!active_reg)
        begin
            sample_calc = '0;
        end
        done_calc = active_reg && (frame_next == chunk_length_reg);
    end

    // Jump condition of the current step.
    always_comb
    begin
        unique case (uc.cond)
            C_NEXT:      jump = 1'b0;
            C_NO_BEAT:   jump = !s_axis_tvalid;
            C_NOT_FIRST: jump = !first_reg;
            C_SHORT:     jump = len_short;
            C_MORE:      jump = cnt_reg != CNT_W'(1);
            C_NO_FADE:   jump = no_fade;
            C_OUT_BUSY:  jump = !out_free;
            default:     jump = 1'b0;
        endcase
    end

    // Next step: jump target, or the following step with wrap at the end.
    always_comb
    begin
        if (jump)
        begin
            step_next = uc.target;
        end
        else if (step_reg == STEP_LAST)
        begin
            step_next = S_WAIT;
        end
        else
        begin
            step_next = step_t'(STEP_W'(step_reg) + STEP_W'(1));
        end
    end

    // Datapath enables decoded from the operation field.
    always_comb
    begin
        ctrl           = '0;
        ctrl.capture   = (uc.op == OP_CAPTURE) && s_axis_tvalid;
        ctrl.load      = (uc.op == OP_LOAD);
        ctrl.div_step  = (uc.op == OP_DIV);
        ctrl.set_inc   = (uc.op == OP_SET_INC);
        ctrl.check     = (uc.op == OP_CHECK);
        ctrl.set_env   = (uc.op == OP_SET_ENV);
        ctrl.mul_load1 = (uc.op == OP_MUL_LOAD1);
        ctrl.mul_load2 = (uc.op == OP_MUL_LOAD2);
        ctrl.mul_step  = (uc.op == OP_MUL);
        ctrl.emit      = (uc.op == OP_EMIT) && out_free;
    end

    // Control state: sequencer, configuration, phase, chunk counters, output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg         <= S_WAIT;
            cnt_reg          <= '0;
            tuning_word_reg  <= '0;
            max_amp_reg      <= MAX_AMP_RESET;
            phase_reg        <= '0;
            frame_index_reg  <= '0;
            chunk_length_reg <= '0;
            edge_length_reg  <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;

            if (cfg_valid)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_TUNING_WORD:   tuning_word_reg <= cfg_data;
                    REG_MAX_AMPLITUDE: max_amp_reg     <= cfg_data[AMP_W-1:0];
                endcase
            end

            if (ctrl.load || ctrl.check)
            begin
                cnt_reg <= CNT_W'(DIV_STEPS);
            end
            else if (ctrl.mul_load1)
            begin
                cnt_reg <= CNT_W'(SINE_W);
            end
            else if (ctrl.mul_load2)
            begin
                cnt_reg <= CNT_W'(ENV_W);
            end
            else if (ctrl.div_step || ctrl.mul_step)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end

            if (ctrl.capture && s_axis_tuser[0])
            begin
                phase_reg <= '0;
            end
            else if (ctrl.emit)
            begin
                phase_reg <= phase_reg + PHASE_BITS'(tuning_word_reg);
            end

            if (ctrl.load)
            begin
                chunk_length_reg <= LEN_W'(len_clamp);
                frame_index_reg  <= '0;
                edge_length_reg  <= edge_calc;
            end
            else if (ctrl.emit && active_reg)
            begin
                frame_index_reg <= frame_next;
            end

            if (ctrl.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: request fields, ramp, divider, multiplier, sample.
    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            first_reg     <= s_axis_tuser[1];
            frames_reg    <= s_axis_tdata[FRAMES_W-1:0];
            amp_start_reg <= s_axis_tdata[FRAMES_W +: AMP_W];
            amp_end_reg   <= s_axis_tdata[FRAMES_W + AMP_W +: AMP_W];
        end

        if (ctrl.load)
        begin
            amp_accum_reg <= {amp0_clamp, {AMP_FRAC{1'b0}}};
            amp_inc_reg   <= '0;
            inc_neg_reg   <= amp_falls;
            div_num_reg   <= {amp_diff, {AMP_FRAC{1'b0}}};
            div_rem_reg   <= '0;
            div_den_reg   <= len_clamp - FRAMES_W'(1);
        end

        if (ctrl.div_step)
        begin
            div_num_reg <= {div_num_reg[DIV_W-2:0], div_qbit};
            div_rem_reg <= div_rem_next;
        end

        if (ctrl.set_inc)
        begin
            amp_inc_reg <= inc_neg_reg ? (ACC_W'(0) - div_num_reg) : div_num_reg;
        end

        // The table read lands in a register; the envelope defaults to unity.
        if (ctrl.check)
        begin
            active_reg   <= frame_live;
            sine_mag_reg <= sine_tab[rom_idx];
            sine_neg_reg <= sine_quad[1];
            env_reg      <= ENV_UNITY;
            div_num_reg  <= DIV_W'({env_num, {ENV_FRAC{1'b0}}});
            div_rem_reg  <= '0;
            div_den_reg  <= FRAMES_W'(edge_length_reg);
        end

        if (ctrl.set_env)
        begin
            env_reg <= div_num_reg[ENV_W-1:0];
        end

        if (ctrl.mul_load1)
        begin
            mul_acc_reg   <= '0;
            mul_cand_reg  <= PROD_W'(amp_accum_reg);
            mul_plier_reg <= ENV_W'(sine_mag_reg);
        end

        if (ctrl.mul_load2)
        begin
            mul_acc_reg   <= '0;
            mul_cand_reg  <= mul_acc_reg;
            mul_plier_reg <= env_reg;
        end

        // Shift-add multiplier step, one multiplier bit per cycle.
        if (ctrl.mul_step)
        begin
            if (mul_plier_reg[0])
            begin
                mul_acc_reg <= mul_acc_reg + mul_cand_reg;
            end
            mul_cand_reg  <= {mul_cand_reg[PROD_W-2:0], 1'b0};
            mul_plier_reg <= {1'b0, mul_plier_reg[ENV_W-1:1]};
        end

        if (ctrl.emit)
        begin
            if (active_reg)
            begin
                amp_accum_reg <= amp_accum_reg + amp_inc_reg;
            end
            out_sample_reg <= sample_calc;
            out_done_reg   <= done_calc;
        end
    end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for sine_tone_ramp_generator: a sample predictor in a
// small scoreboard class, plus stream and register drivers with random idling.
// Depends on strg_pkg and the RTL top level.
module tb
    import strg_pkg::*;
();

    localparam int        CHUNK_LIMIT = 256;
    localparam longint    RUN_LIMIT_NS = 64'd8_000_000;
    localparam int        PHASE_ITEMS = 220;
    localparam int        SETTINGS_N = 5;

    // One frame request as the block sees it.
    typedef struct packed {
        logic        start_tone;
        logic        chunk_first;
        logic [8:0]  frames;
        logic [14:0] amp_start;
        logic [14:0] amp_end;
    } tone_req_t;

    // One sample beat as the block returns it.
    typedef struct packed {
        logic [15:0] sample;
        logic        done;
    } sample_beat_t;

    // Predicts every sample beat and checks what the block returns, in order.
    class tone_scoreboard_t;
        logic [15:0]  tuning_word;
        logic [14:0]  max_amp;
        logic [15:0]  phase;
        logic [8:0]   frame_idx;
        logic [8:0]   chunk_len;
        logic [6:0]   edge_len;
        logic [24:0]  amp_acc;
        logic [25:0]  amp_inc;
        logic [14:0]  sine_quarter [0:256];
        sample_beat_t pending_samples [$];
        int           errors;
        int           checked;
        int           loads;
        int           fade_frames;
        int           chunk_ends;

        function new();
            longint unsigned y, y2, term, sum;
            int num, n;
            tuning_word = '0;
            max_amp    = MAX_AMP_RESET;
            phase      = '0;
            frame_idx  = '0;
            chunk_len  = '0;
            edge_len   = '0;
            amp_acc    = '0;
            amp_inc    = '0;
            errors     = 0;
            checked    = 0;
            loads      = 0;
            fade_frames = 0;
            chunk_ends = 0;
            // Quarter-wave sine: Taylor series in Q30, scaled to unsigned Q0.15 with
            // rounding half up.
            for (num = 0; num <= 256; num++)
            begin
                y = num;
                y = (y * 64'd1686629713) >> 8;
                y2 = (y * y) >> 30;
                term = y;
                sum = y;
                for (n = 1; n <= 7; n++)
                begin
                    term = ((term * y2) >> 30) / ((2 * n) * (2 * n + 1));
                    if (n % 2 == 1)
                        sum = sum - term;
                    else
                        sum = sum + term;
                end
                sine_quarter[num] = 15'((sum * 64'd32767 + 64'h2000_0000) >> 30);
            end
        endfunction

        function void write_reg(cfg_reg_t idx, logic [15:0] value);
            case (idx)
                REG_TUNING_WORD:   tuning_word = value;
                REG_MAX_AMPLITUDE: max_amp = value[14:0];
                default:           ;
            endcase
        endfunction

        function int pending();
            return pending_samples.size();
        endfunction

        // Works out the sample of one frame request and advances the state.
        function sample_beat_t predict_frame(tone_req_t req);
            sample_beat_t    beat;
            int unsigned     len, a0, a1, diff, step_mag, i, num;
            logic [9:0]      addr;
            longint unsigned env, s_mag, a_mag, prod;
            logic            neg;
            beat.sample = '0;
            beat.done = 1'b0;
            if (req.start_tone)
                phase = '0;
            // Chunk load: clamp length and amplitudes, set ramp and fade size.
            if (req.chunk_first)
            begin
                len = req.frames;
                if (len == 0)
                    len = 1;
                if (len > CHUNK_LIMIT)
                    len = CHUNK_LIMIT;
                a0 = req.amp_start;
                a1 = req.amp_end;
                if (a0 > max_amp)
                    a0 = max_amp;
                if (a1 > max_amp)
                    a1 = max_amp;
                chunk_len = 9'(len);
                frame_idx = '0;
                edge_len = '0;
                if (len > 32)
                    edge_len = 7'((len / 8 < 80) ? len / 8 : 80);
                amp_acc = 25'(a0 << 10);
                amp_inc = '0;
                if (len > 1)
                begin
                    diff = (a1 >= a0) ? a1 - a0 : a0 - a1;
                    step_mag = (diff << 10) / (len - 1);
                    amp_inc = 26'((a1 >= a0) ? step_mag : -step_mag);
                end
                loads++;
            end
            // Sample of a running chunk; an exhausted chunk gives silence.
            if (frame_idx < chunk_len)
            begin
                i = frame_idx;
                addr = phase[15:6];
                num = addr[8] ? 256 - addr[7:0] : addr[7:0];
                neg = addr[9];
                env = 65536;
                if (edge_len != 0)
                begin
                    if (i < edge_len)
                    begin
                        env = ((i + 1) << 16) / edge_len;
                        fade_frames++;
                    end
                    else if (i >= chunk_len - edge_len)
                    begin
                        env = ((chunk_len - i) << 16) / edge_len;
                        fade_frames++;
                    end
                end
                s_mag = sine_quarter[num];
                a_mag = amp_acc;
                prod = (s_mag * a_mag * env) >> 41;
                if (neg)
                begin
                    if (prod > 32768)
                        prod = 32768;
                    beat.sample = -(prod[15:0]);
                end
                else
                begin
                    if (prod > 32767)
                        prod = 32767;
                    beat.sample = prod[15:0];
                end
                beat.done = (i + 1 == chunk_len);
                amp_acc = amp_acc + amp_inc[24:0];
                frame_idx = 9'(i + 1);
            end
            phase = phase + tuning_word;
            return beat;
        endfunction

        function void note_request(tone_req_t req);
            pending_samples.push_back(predict_frame(req));
        endfunction

        function void check_sample(logic [15:0] got_sample, logic got_last);
            sample_beat_t want;
            if (pending_samples.size() == 0)
            begin
                $display("%0t: sample beat %0d with no request waiting", $time,
                         $signed(got_sample));
                errors++;
                return;
            end
            want = pending_samples.pop_front();
            checked++;
            if (want.done)
                chunk_ends++;
            if (got_sample !== want.sample)
            begin
                $display("%0t: sample mismatch, expected %0d, actual %0d", $time,
                         $signed(want.sample), $signed(got_sample));
                errors++;
            end
            if (got_last !== want.done)
            begin
                $display("%0t: chunk end mismatch, expected %0b, actual %0b", $time,
                         want.done, got_last);
                errors++;
            end
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic [IN_TUSER_W-1:0]  s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    tone_scoreboard_t sb = new();
    int idle_pct = 27;
    int settings_run = 0;

    // Register settings per random phase, extremes included; the second
    // max_amplitude value has its dropped top bit set.
    logic [15:0] step_set [SETTINGS_N] = '{16'h0000, 16'hFFFF, 16'h0001, 16'h0BAD, 16'h2EB7};
    logic [15:0] max_set  [SETTINGS_N] = '{16'h7FFF, 16'hFFFF, 16'h0000, 16'h36B0, 16'd14000};

    sine_tone_ramp_generator #(
        .CHUNK_MAX      (CHUNK_LIMIT),
        .PHASE_BITS     (16),
        .SINE_ADDR_BITS (10)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

    // Sample side: check each accepted beat, stall at random.
    initial
    begin
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
                sb.check_sample(m_axis_tdata, m_axis_tlast);
            m_axis_tready <= !(idle_pct != 0 && $urandom_range(99) < idle_pct);
        end
    end

    // Sends one frame request, with random idle cycles ahead of it.
    task automatic send_frame(input logic st, input logic first, input logic [8:0] frames,
                              input logic [14:0] a0, input logic [14:0] a1);
        tone_req_t req;
        req.start_tone  = st;
        req.chunk_first = first;
        req.frames      = frames;
        req.amp_start   = a0;
        req.amp_end     = a1;
        while (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, a1, a0, frames};
        s_axis_tuser  <= {first, st};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_request(req);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.write_reg(idx, value);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Stops requests and waits until every predicted sample has come back.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    // Mostly whole chunks with random content, plus stray and cut-off frames.
    task automatic run_random(input int n_items);
        int sent, len, eff, take, k, pick;
        sent = 0;
        while (sent < n_items)
        begin
            pick = $urandom_range(99);
            if (pick < 82)
            begin
                pick = $urandom_range(99);
                if (pick < 60)
                    len = $urandom_range(32);
                else if (pick < 90)
                    len = $urandom_range(100, 33);
                else if (pick < 97)
                    len = $urandom_range(CHUNK_LIMIT, 101);
                else
                    len = $urandom_range(511, CHUNK_LIMIT + 1);
                eff = (len == 0) ? 1 : ((len > CHUNK_LIMIT) ? CHUNK_LIMIT : len);
                take = eff;
                if ($urandom_range(99) < 8)
                    take = $urandom_range(eff, 1);
                // The last chunk of a phase is cut off at the item budget.
                if (take > n_items - sent)
                    take = n_items - sent;
                send_frame($urandom_range(99) < 15, 1'b1, 9'(len),
                           15'($urandom_range(32767)), 15'($urandom_range(32767)));
                for (k = 1; k < take; k++)
                    send_frame($urandom_range(99) < 3, 1'b0, 9'($urandom_range(511)),
                               15'($urandom_range(32767)), 15'($urandom_range(32767)));
                sent += take;
            end
            else if (pick < 94)
            begin
                // Frames past the end of a chunk.
                for (k = $urandom_range(4, 1); k > 0; k--)
                begin
                    send_frame(1'($urandom_range(1)), 1'b0, 9'($urandom_range(511)),
                               15'($urandom_range(32767)), 15'($urandom_range(32767)));
                    sent++;
                end
            end
            else
            begin
                send_frame(1'($urandom_range(1)), 1'($urandom_range(1)),
                           9'($urandom_range(511)),
                           15'($urandom_range(32767)), 15'($urandom_range(32767)));
                sent++;
            end
        end
    endtask

    // Main sequence: reset, directed frames, then random phases per setting.
    initial
    begin
        int p;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        cfg_valid     <= 1'b0;
        cfg_index     <= REG_TUNING_WORD;
        cfg_data      <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_reg(REG_TUNING_WORD, 16'd3125);
        write_reg(REG_MAX_AMPLITUDE, 16'd20000);
        settings_run++;

        // No chunk loaded yet: silence.
        send_frame(1'b1, 1'b0, 9'd5, 15'd1000, 15'd1000);
        // Zero length taken as one frame, start above the ceiling.
        send_frame(1'b0, 1'b1, 9'd0, 15'h7FFF, 15'd0);
        // Exhausted chunk: silence, no chunk end.
        send_frame(1'b0, 1'b0, 9'd0, 15'd0, 15'd0);
        // Single-frame chunk.
        send_frame(1'b0, 1'b1, 9'd1, 15'd5000, 15'd30000);
        // Short falling ramp from a clamped start.
        send_frame(1'b1, 1'b1, 9'd3, 15'h7FFF, 15'd0);
        send_frame(1'b0, 1'b0, 9'd0, 15'd0, 15'd0);
        send_frame(1'b0, 1'b0, 9'h1FF, 15'h7FFF, 15'h7FFF);
        // Overlong chunk, cut short by the next load.
        send_frame(1'b0, 1'b1, 9'h1FF, 15'd12000, 15'd20000);
        send_frame(1'b0, 1'b0, 9'd0, 15'd0, 15'd0);
        send_frame(1'b1, 1'b0, 9'd0, 15'd0, 15'd0);
        send_frame(1'b0, 1'b0, 9'd0, 15'd0, 15'd0);
        // Zero amplitude.
        send_frame(1'b0, 1'b1, 9'd2, 15'd0, 15'd0);
        send_frame(1'b0, 1'b0, 9'd0, 15'd0, 15'd0);
        // Rising ramp to a clamped end, phase restart in the middle.
        send_frame(1'b0, 1'b1, 9'd5, 15'd0, 15'h7FFF);
        send_frame(1'b0, 1'b0, 9'd0, 15'd0, 15'd0);
        send_frame(1'b1, 1'b0, 9'd0, 15'd0, 15'd0);
        send_frame(1'b0, 1'b0, 9'd0, 15'd0, 15'd0);
        send_frame(1'b0, 1'b0, 9'd0, 15'd0, 15'd0);
        // Exactly the longest chunk.
        send_frame(1'b0, 1'b1, 9'd256, 15'd20000, 15'd20000);
        send_frame(1'b0, 1'b0, 9'd0, 15'd0, 15'd0);
        drain();

        for (p = 0; p < SETTINGS_N; p++)
        begin
            write_reg(REG_TUNING_WORD, step_set[p]);
            write_reg(REG_MAX_AMPLITUDE, max_set[p]);
            settings_run++;
            idle_pct = (p == 3) ? 0 : 27;
            run_random(PHASE_ITEMS);
            drain();
        end
        idle_pct = 27;

        repeat (100) @(posedge clk);
        $display("Checked %0d sample beats: %0d chunk loads, %0d fade frames, %0d chunk ends.",
                 sb.checked, sb.loads, sb.fade_frames, sb.chunk_ends);
        $display("Covered %0d register settings, one stretch without idle cycles.",
                 settings_run);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
